@@ src/gzmd_pkg.sv @@
`default_nettype none
package gzmd_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned TDATA_W    = 48;

	localparam logic [7:0] ID1    = 8'h1f;
	localparam logic [7:0] ID2    = 8'h8b;
	localparam logic [7:0] CM_DEF = 8'h08;

	// flag bit positions
	localparam int unsigned F_HCRC    = 1;
	localparam int unsigned F_EXTRA   = 2;
	localparam int unsigned F_NAME    = 3;
	localparam int unsigned F_COMMENT = 4;

	localparam logic [4:0] CNT_FULL  = 5'd18;
	localparam logic [4:0] CNT_DELAY = 5'd8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD      = 2'd1;
	localparam logic [1:0] ST_SIZE     = 2'd2;
	localparam logic [1:0] ST_TRUNC    = 2'd3;

	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_XLEN_LO = 4'd1,
		PH_XLEN_HI = 4'd2,
		PH_XSKIP   = 4'd3,
		PH_NAME    = 4'd4,
		PH_COMMENT = 4'd5,
		PH_HCRC    = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_DROP    = 4'd8
	} phase_t;

	// one queue entry: what one accepted byte produced
	typedef struct packed {
		logic        pay_v;
		logic [7:0]  pay_byte;
		logic        st_v;
		logic [1:0]  st;
		logic [31:0] size;
	} entry_t;

	// first enabled metadata section after section s, else payload
	function automatic phase_t next_stage(phase_t s, logic [4:0] fl);
		phase_t n;
		n = PH_PAYLOAD;
		if (s < PH_XLEN_LO && fl[F_EXTRA]) n = PH_XLEN_LO;
		else if (s < PH_NAME && fl[F_NAME]) n = PH_NAME;
		else if (s < PH_COMMENT && fl[F_COMMENT]) n = PH_COMMENT;
		else if (s < PH_HCRC && fl[F_HCRC]) n = PH_HCRC;
		return n;
	endfunction

endpackage
`default_nettype wire

@@ src/gzmd_front.sv @@
`default_nettype none
module gzmd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              in_last,
	input  wire logic [31:0]       expected_size,
	output logic                   push,
	output gzmd_pkg::entry_t       entry
);

	logic [7:0]        dl_q [8];
	logic [4:0]        cnt_q;
	gzmd_pkg::phase_t  phase_q, ph_d;
	logic [15:0]       fc_q, fc_d;
	logic [4:0]        flags_q, fl_d;
	logic [1:0]        err_q, err_d;
	logic              is_pay;
	logic [31:0]       size;
	logic [7:0]        old;

	assign old = dl_q[0];

	// parser next state for the byte leaving the delay line
	always_comb begin
		logic bad;
		logic adv;
		gzmd_pkg::phase_t adv_from;
		bad      = 1'b0;
		adv      = 1'b0;
		adv_from = phase_q;
		ph_d     = phase_q;
		fc_d     = fc_q;
		fl_d     = flags_q;
		err_d    = err_q;
		is_pay   = 1'b0;
		if (cnt_q >= gzmd_pkg::CNT_DELAY) begin
			unique case (phase_q)
				gzmd_pkg::PH_HDR: begin
					bad = (fc_q == 16'd0 && old != gzmd_pkg::ID1) ||
					      (fc_q == 16'd1 && old != gzmd_pkg::ID2) ||
					      (fc_q == 16'd2 && old != gzmd_pkg::CM_DEF) ||
					      (fc_q == 16'd3 && old[7:5] != 3'd0);
					if (bad) begin
						err_d[0] = 1'b1;
						ph_d     = gzmd_pkg::PH_DROP;
					end else begin
						if (fc_q == 16'd3) fl_d = old[4:0];
						fc_d = fc_q + 16'd1;
						if (fc_q >= 16'd9) begin
							adv      = 1'b1;
							adv_from = gzmd_pkg::PH_HDR;
						end
					end
				end
				gzmd_pkg::PH_XLEN_LO: begin
					fc_d = {8'd0, old};
					ph_d = gzmd_pkg::PH_XLEN_HI;
				end
				gzmd_pkg::PH_XLEN_HI: begin
					fc_d = {old, fc_q[7:0]};
					if ({old, fc_q[7:0]} == 16'd0) begin
						adv      = 1'b1;
						adv_from = gzmd_pkg::PH_XLEN_LO;
					end else begin
						ph_d = gzmd_pkg::PH_XSKIP;
					end
				end
				gzmd_pkg::PH_XSKIP: begin
					fc_d = fc_q - 16'd1;
					if (fc_q == 16'd1) begin
						adv      = 1'b1;
						adv_from = gzmd_pkg::PH_XLEN_LO;
					end
				end
				gzmd_pkg::PH_NAME, gzmd_pkg::PH_COMMENT: begin
					if (old == 8'd0) adv = 1'b1;
				end
				gzmd_pkg::PH_HCRC: begin
					fc_d = fc_q + 16'd1;
					if (fc_q >= 16'd1) begin
						adv      = 1'b1;
						adv_from = gzmd_pkg::PH_HCRC;
					end
				end
				gzmd_pkg::PH_PAYLOAD: is_pay = 1'b1;
				default: ;
			endcase
			if (adv) begin
				ph_d = gzmd_pkg::next_stage(adv_from, flags_q);
				fc_d = 16'd0;
				if (ph_d == gzmd_pkg::PH_PAYLOAD) err_d[1] = 1'b1;
			end
		end
	end

	// trailer size as it sits in the delay line after this shift
	assign size = {in_byte, dl_q[7], dl_q[6], dl_q[5]};

	always_comb begin
		entry          = '0;
		entry.pay_v    = is_pay;
		entry.pay_byte = old;
		entry.st_v     = in_last;
		if (cnt_q < (gzmd_pkg::CNT_FULL - 5'd1) || err_d[0]) begin
			entry.st   = gzmd_pkg::ST_BAD;
			entry.size = 32'd0;
		end else if (size != expected_size) begin
			entry.st   = gzmd_pkg::ST_SIZE;
			entry.size = size;
		end else if (!err_d[1]) begin
			entry.st   = gzmd_pkg::ST_TRUNC;
			entry.size = size;
		end else begin
			entry.st   = gzmd_pkg::ST_OK;
			entry.size = size;
		end
	end

	assign push = accept && (is_pay || in_last);

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 7; i++) dl_q[i] <= dl_q[i+1];
			dl_q[7] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 5'd0;
			phase_q <= gzmd_pkg::PH_HDR;
			fc_q    <= 16'd0;
			flags_q <= 5'd0;
			err_q   <= 2'd0;
		end else if (accept) begin
			if (in_last) begin
				cnt_q   <= 5'd0;
				phase_q <= gzmd_pkg::PH_HDR;
				fc_q    <= 16'd0;
				flags_q <= 5'd0;
				err_q   <= 2'd0;
			end else begin
				if (cnt_q < gzmd_pkg::CNT_FULL) cnt_q <= cnt_q + 5'd1;
				phase_q <= ph_d;
				fc_q    <= fc_d;
				flags_q <= fl_d;
				err_q   <= err_d;
			end
		end
	end

	a_payload_after_meta: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == gzmd_pkg::PH_PAYLOAD |-> err_q[1])
		else $error("payload phase without completed metadata");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> cnt_q == 5'd0 && phase_q == gzmd_pkg::PH_HDR)
		else $error("member state not cleared after last byte");

	a_idle_before_delay: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < gzmd_pkg::CNT_DELAY |-> phase_q == gzmd_pkg::PH_HDR && fc_q == 16'd0)
		else $error("parser moved before delay line filled");

endmodule
`default_nettype wire

@@ src/gzmd_fifo.sv @@
`default_nettype none
module gzmd_fifo #(
	parameter int unsigned DEPTH = gzmd_pkg::FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire gzmd_pkg::entry_t push_data,
	input  wire logic             pop,
	output gzmd_pkg::entry_t      head,
	output logic                  head_v,
	output logic                  full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	gzmd_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign head_v = (cnt_q != '0);
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!head_v |-> !pop)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ src/gzmd_back.sv @@
`default_nettype none
module gzmd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire gzmd_pkg::entry_t               head,
	input  wire logic                           head_v,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [gzmd_pkg::TDATA_W-1:0]        m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast
);

	gzmd_pkg::entry_t cur_q;
	logic             pay_q, st_q;
	logic             fire, pay_n, st_n;

	// payload byte goes first, status after it
	assign fire  = m_tvalid && m_tready;
	assign pay_n = pay_q && !fire;
	assign st_n  = st_q && !(fire && !pay_q);
	assign pop   = head_v && !pay_n && !st_n;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_q <= 1'b0;
			st_q  <= 1'b0;
		end else if (pop) begin
			pay_q <= head.pay_v;
			st_q  <= head.st_v;
		end else begin
			pay_q <= pay_n;
			st_q  <= st_n;
		end
	end

	assign m_tvalid = pay_q || st_q;
	assign m_tuser  = !pay_q && st_q;
	assign m_tlast  = !pay_q && st_q;
	assign m_tdata  = pay_q ? {40'd0, cur_q.pay_byte}
	                        : {6'd0, cur_q.size, cur_q.st, 8'd0};

	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && m_tuser && !pop |=> !st_q)
		else $error("status result repeated");

	a_pay_before_status: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pay_q && st_q |=> st_q && !pay_q)
		else $error("status lost behind payload");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(pay_q))
		else $error("output dropped while stalled");

endmodule
`default_nettype wire

@@ src/gzip_member_deframer.sv @@
`default_nettype none
// channel | dir | signals                    | contents
// s_*     | in  | tvalid tready tdata tlast  | tdata[7:0] in_byte; tlast in_last
// m_*     | out | tvalid tready tdata tuser  | tdata: out_byte, status, trailer_size
//         |     | tlast                      | tuser is_status; tlast out_last
// cfg_*   | in  | we wdata                   | expected_size
//
// One byte is accepted per cycle; the front parser updates its state in that cycle.
// Payload leaving the eight-byte delay line is queued, then registered at m_*;
// the last byte of a member yields up to two results, drained one per ready cycle.
// s_tready drops only while the FIFO_DEPTH entry queue between parser and
// output stage is full. Reset is asynchronous and needs no clearing pass.
module gzip_member_deframer #(
	parameter int unsigned FIFO_DEPTH = gzmd_pkg::FIFO_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,   // in_byte
	input  wire logic                        s_tlast,   // in_last
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// out_byte[7:0], status[9:8], trailer_size[41:10], zero fill
	output logic [gzmd_pkg::TDATA_W-1:0]     m_tdata,
	output logic                             m_tuser,   // is_status
	output logic                             m_tlast,   // out_last
	input  wire logic                        cfg_we,
	input  wire logic [31:0]                 cfg_wdata  // expected_size
);

	logic [31:0]      exp_size_q;
	logic             accept, push, pop, head_v, full;
	gzmd_pkg::entry_t entry, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) exp_size_q <= 32'd0;
		else if (cfg_we) exp_size_q <= cfg_wdata;
	end

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	gzmd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.in_byte       (s_tdata),
		.in_last       (s_tlast),
		.expected_size (exp_size_q),
		.push          (push),
		.entry         (entry)
	);

	gzmd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.head_v    (head_v),
		.full      (full)
	);

	gzmd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_v   (head_v),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

@@ tb/tb_gzip_member_deframer.sv @@
module tb_gzip_member_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import gzmd_pkg::*;

	typedef struct packed {
		logic [7:0]  data;
		logic        is_st;
		logic [1:0]  st;
		logic [31:0] size;
		logic        last;
	} gz_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                s_tlast = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;
	logic                m_tlast;
	logic                cfg_we = 1'b0;
	logic [31:0]         cfg_wdata = '0;

	// payload bytes and status words the deframer must still emit, oldest first
	gz_result_t          predicted_out[$];
	// {last, byte} pairs waiting to be offered on the slave side
	logic [8:0]          member_bytes_q[$];
	logic [7:0]          member_buf[$];

	// predictor state
	logic [7:0]          win [8];
	logic [4:0]          win_fill;
	phase_t              ph;
	logic [15:0]         sect_cnt;
	logic [4:0]          flags;
	logic                hdr_bad;
	logic                meta_done;
	logic [31:0]         want_size;

	logic [31:0]         size_setting = '0;
	int unsigned         sent_bytes = 0;
	int unsigned         bytes_taken = 0;
	int                  errors = 0;
	logic                s_took = 1'b0;
	int unsigned         gap_left = 0;
	int unsigned         hold_left = 0;
	int unsigned         long_holds = 0;
	bit                  tx_steady = 1'b0;
	bit                  rx_steady = 1'b0;
	logic [8:0]          tx_item;
	int unsigned         quiet = 0;

	gzip_member_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic clear_member();
		foreach (win[i]) win[i] = '0;
		win_fill = '0;
		ph = PH_HDR;
		sect_cnt = '0;
		flags = '0;
		hdr_bad = 1'b0;
		meta_done = 1'b0;
	endtask

	// next metadata section enabled by the flags, or payload once all are done
	function automatic phase_t after_section(phase_t s);
		phase_t n;
		n = PH_PAYLOAD;
		if (s < PH_XLEN_LO && flags[F_EXTRA]) n = PH_XLEN_LO;
		else if (s < PH_NAME && flags[F_NAME]) n = PH_NAME;
		else if (s < PH_COMMENT && flags[F_COMMENT]) n = PH_COMMENT;
		else if (s < PH_HCRC && flags[F_HCRC]) n = PH_HCRC;
		sect_cnt = '0;
		if (n == PH_PAYLOAD) meta_done = 1'b1;
		return n;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic last);
		logic [7:0]  old;
		logic        pay;
		logic [31:0] sz;
		logic [1:0]  st;
		pay = 1'b0;
		old = win[0];
		// only bytes that can no longer be trailer reach the parser
		if (win_fill >= CNT_DELAY) begin
			case (ph)
				PH_HDR: begin
					if ((sect_cnt == 0 && old != ID1) || (sect_cnt == 1 && old != ID2) ||
							(sect_cnt == 2 && old != CM_DEF) ||
							(sect_cnt == 3 && old[7:5] != 3'b000)) begin
						hdr_bad = 1'b1;
						ph = PH_DROP;
					end else begin
						if (sect_cnt == 3) flags = old[4:0];
						if (sect_cnt >= 9) ph = after_section(PH_HDR);
						else sect_cnt = sect_cnt + 16'd1;
					end
				end
				PH_XLEN_LO: begin
					sect_cnt = {8'h00, old};
					ph = PH_XLEN_HI;
				end
				PH_XLEN_HI: begin
					sect_cnt[15:8] = old;
					if (sect_cnt == 0) ph = after_section(PH_XLEN_LO);
					else ph = PH_XSKIP;
				end
				PH_XSKIP: begin
					sect_cnt = sect_cnt - 16'd1;
					if (sect_cnt == 0) ph = after_section(PH_XLEN_LO);
				end
				PH_NAME, PH_COMMENT: begin
					if (old == 8'h00) ph = after_section(ph);
				end
				PH_HCRC: begin
					sect_cnt = sect_cnt + 16'd1;
					if (sect_cnt >= 16'd2) ph = after_section(PH_HCRC);
				end
				PH_PAYLOAD: pay = 1'b1;
				default: ;
			endcase
		end
		if (pay) predicted_out.push_back('{old, 1'b0, ST_OK, 32'h0, 1'b0});
		for (int i = 0; i < 7; i++) win[i] = win[i + 1];
		win[7] = b;
		if (win_fill < CNT_FULL) win_fill = win_fill + 5'd1;
		if (last) begin
			sz = {win[7], win[6], win[5], win[4]};
			if (win_fill < CNT_FULL || hdr_bad) begin
				st = ST_BAD;
				sz = '0;
			end else if (sz != want_size) st = ST_SIZE;
			else if (!meta_done) st = ST_TRUNC;
			else st = ST_OK;
			predicted_out.push_back('{8'h00, 1'b1, st, sz, 1'b1});
			clear_member();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// monitor and predictor: results checked before this edge's input is predicted
	always @(posedge clk) begin
		gz_result_t r;
		s_took <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (predicted_out.size() == 0) begin
					$error("result with nothing expected: tdata %0h tuser %0b", m_tdata, m_tuser);
					errors++;
				end else begin
					r = predicted_out.pop_front();
					check_field("out_byte", 32'(r.data), 32'(m_tdata[7:0]));
					check_field("is_status", 32'(r.is_st), 32'(m_tuser));
					check_field("status", 32'(r.st), 32'(m_tdata[9:8]));
					check_field("trailer_size", r.size, m_tdata[41:10]);
					check_field("out_last", 32'(r.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (cfg_we) want_size = cfg_wdata;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet <= 0;
		end else if (quiet == 2000) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_took) begin
			// transaction still pending, hold everything
		end else if (gap_left != 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (member_bytes_q.size() != 0) begin
			tx_item = member_bytes_q.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= tx_item[7:0];
			s_tlast <= tx_item[8];
			if ($urandom_range(0, 40) == 0) tx_steady = !tx_steady;
			gap_left = tx_steady ? 0 : pick_idle();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (long_holds < 2 && bytes_taken >= 300 * (long_holds + 1)) begin
			// long back-pressure so the output queue fills and s_tready drops
			long_holds++;
			hold_left = 79;
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 40) == 0) rx_steady = !rx_steady;
			hold_left = rx_steady ? 0 : pick_idle();
			m_tready <= (hold_left == 0);
			if (hold_left != 0) hold_left--;
		end
	end

	task automatic put_header(input logic [7:0] flg);
		member_buf.push_back(ID1);
		member_buf.push_back(ID2);
		member_buf.push_back(CM_DEF);
		member_buf.push_back(flg);
		repeat (6) member_buf.push_back(8'($urandom));
	endtask

	task automatic put_random(input int unsigned n);
		repeat (n) member_buf.push_back(8'($urandom));
	endtask

	task automatic put_zstring();
		repeat ($urandom_range(0, 4)) member_buf.push_back(8'($urandom_range(1, 255)));
		member_buf.push_back(8'h00);
	endtask

	task automatic put_trailer(input logic [31:0] sz);
		put_random(4);
		for (int i = 0; i < 4; i++) member_buf.push_back(sz[8 * i +: 8]);
	endtask

	task automatic send_member();
		foreach (member_buf[i])
			member_bytes_q.push_back({i == member_buf.size() - 1, member_buf[i]});
		sent_bytes += member_buf.size();
		member_buf.delete();
	endtask

	task automatic queue_random_member();
		logic [7:0]  flg;
		int unsigned pick;
		int unsigned xlen;
		int unsigned keep;
		pick = $urandom_range(0, 99);
		if (pick >= 95) begin
			// raw noise, sometimes with a valid-looking signature
			if (pick >= 98) begin
				member_buf.push_back(ID1);
				member_buf.push_back(ID2);
			end
			put_random($urandom_range(1, 30));
			send_member();
			return;
		end
		flg = {3'b000, 5'($urandom)};
		if (pick < 5) flg[7:5] = 3'($urandom_range(1, 7));
		put_header(flg);
		if (pick >= 5 && pick < 10)
			member_buf[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
		if (flg[F_EXTRA]) begin
			xlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			member_buf.push_back(xlen[7:0]);
			member_buf.push_back(xlen[15:8]);
			put_random(xlen);
		end
		if (flg[F_NAME]) put_zstring();
		if (flg[F_COMMENT]) put_zstring();
		if (flg[F_HCRC]) put_random(2);
		put_random($urandom_range(0, 20));
		// cut the member short so metadata or header overlaps the trailer
		if (pick >= 10 && pick < 22) begin
			keep = $urandom_range(0, member_buf.size());
			while (member_buf.size() > keep) void'(member_buf.pop_back());
		end
		put_trailer(($urandom_range(0, 3) != 0) ? size_setting : 32'($urandom));
		send_member();
	endtask

	task automatic write_size(input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		size_setting = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// all bytes taken and every result seen, then let the pipeline settle
	task automatic drain();
		while (member_bytes_q.size() != 0 || s_tvalid || predicted_out.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		logic [31:0] sizes [4];
		int unsigned target;
		clear_member();
		want_size = '0;
		sizes[0] = 32'h0000_0000;
		sizes[1] = $urandom;
		sizes[2] = 32'hffff_ffff;
		sizes[3] = $urandom_range(0, 255);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_size(32'h0);
		put_header(8'h00);                 // metadata ends right at the trailer
		put_trailer(32'h0);
		send_member();
		put_random(5);                     // too short
		send_member();
		put_random(1);
		send_member();
		put_header(8'h00);
		member_buf[0] = 8'h1e;             // bad first id, payload must be dropped
		put_random(4);
		put_trailer(32'h0);
		send_member();
		put_header(8'h00);
		member_buf[1] = 8'h8a;
		put_trailer(32'h0);
		send_member();
		put_header(8'h00);
		member_buf[2] = 8'h07;             // not deflate
		put_trailer(32'h0);
		send_member();
		put_header(8'h20);                 // reserved flag
		put_random(2);
		put_trailer(32'h0);
		send_member();
		put_header(8'h08);                 // name never terminated
		member_buf.push_back(8'h61);
		member_buf.push_back(8'h62);
		put_trailer(32'h0);
		send_member();
		drain();

		write_size(32'hffff_ffff);
		put_header(8'h1f);                 // every section present
		member_buf.push_back(8'h02);
		member_buf.push_back(8'h00);
		put_random(2);
		member_buf.push_back(8'h78);
		member_buf.push_back(8'h00);
		member_buf.push_back(8'h00);
		put_random(2);
		member_buf.push_back(8'h00);
		member_buf.push_back(8'hff);
		member_buf.push_back(8'h5a);
		put_trailer(32'hffff_ffff);
		send_member();
		put_header(8'h00);
		put_random(3);
		put_trailer(32'hffff_fffe);
		send_member();
		put_header(8'h04);                 // extra length 0x0102 runs into trailer
		member_buf.push_back(8'h02);
		member_buf.push_back(8'h01);
		put_random(4);
		put_trailer(32'hffff_ffff);
		send_member();
		put_header(8'h10);                 // truncated comment and wrong size together
		member_buf.push_back(8'h41);
		put_trailer(32'h0);
		send_member();
		put_header(8'h02);
		put_random(1);
		put_trailer(32'hffff_ffff);
		send_member();
		drain();

		foreach (sizes[i]) begin
			write_size(sizes[i]);
			target = sent_bytes + 140;
			while (sent_bytes < target) queue_random_member();
			drain();
		end

		if (errors == 0 && predicted_out.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
